/* rtl/sjb_pkg.sv */
// Shared constants, command codes and controller/datapath interface types
// for the sequence-slot jitter buffer. No dependencies.
package sjb_pkg;

    // Number of frame slots; must be a power of two so the slot is the low
    // bits of the sequence number.
    localparam int SLOTS       = 256;
    // Number of 64-bit words in one frame.
    localparam int FRAME_WORDS = 20;

    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int MEM_DEPTH = SLOTS * FRAME_WORDS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    // Word counter width: holds FRAME_WORDS itself and covers the 5-bit index field.
    localparam int CNT_W     = ($clog2(FRAME_WORDS + 1) > 5) ? $clog2(FRAME_WORDS + 1) : 5;

    // Command codes of the input word.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             write_en;
        logic             start_hit;
        logic             start_miss;
        logic             read_en;
        logic [CNT_W-1:0] read_idx;
        logic             read_last;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_hit;
        logic rd_free;
    } dp_status_t;

endpackage

/* rtl/seq_slot_jitter_buffer_core.sv */
// Top level of the sequence-slot jitter buffer: joins the controller and
// the datapath. Depends on sjb_pkg, sjb_ctrl and sjb_datapath.
//
// A frame-word write (command 0) is taken and gives no result; while no frame
// is being read out, writes stream at one word per cycle into the single-port
// payload memory. A playout tick (command 1) on a ready slot reads the frame's
// FRAME_WORDS words from that memory one per cycle, unless the output stalls;
// a tick on an empty slot gives one miss result. Results pass through a
// registered read stage and then an output register. No input is taken while
// a frame is being read out. The ready bits are cleared by reset at once; the
// payload memory needs no clearing.
module seq_slot_jitter_buffer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [31:0] packet_seq,
    input  logic        is_redundant,
    input  logic [4:0]  word_index,
    input  logic [63:0] word_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_seq,
    output logic [4:0]  out_index,
    output logic [63:0] out_value,
    output logic        missed,
    output logic        last_of_run
);

    sjb_pkg::ctrl_cmd_t  cmd;
    sjb_pkg::dp_status_t status;

    // Controller: handshake and playout sequencing.
    sjb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: storage, counters and result registers.
    sjb_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .packet_seq   (packet_seq),
        .is_redundant (is_redundant),
        .word_index   (word_index),
        .word_value   (word_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_seq      (out_seq),
        .out_index    (out_index),
        .out_value    (out_value),
        .missed       (missed),
        .last_of_run  (last_of_run)
    );

    // A miss result is always the only, and so the last, result of its tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && missed |-> last_of_run && (out_index == 5'd0) && (out_value == 64'd0))
        else $error("miss result malformed");

    // A played word is last exactly when it is the frame's final word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !missed |->
            (last_of_run == (out_index == 5'(sjb_pkg::FRAME_WORDS - 1))))
        else $error("last_of_run does not match frame end");

    // Once a tick hits a ready slot, input is held off while the frame plays.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_hit && (sjb_pkg::FRAME_WORDS > 1) |=> !in_ready)
        else $error("input taken during frame playout");

    // The controller never issues a write and a playout start together.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.write_en, cmd.start_hit, cmd.start_miss}) <= 1)
        else $error("conflicting datapath commands");

endmodule

/* rtl/sjb_ctrl.sv */
// Controller state machine of the jitter buffer: input handshake and the
// word sequencer for frame playout. Depends on sjb_pkg.
module sjb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                command,
    input  sjb_pkg::dp_status_t status,
    output sjb_pkg::ctrl_cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_PLAY = 1'b1;

    logic                      state_reg;
    logic                      state_next;
    logic [sjb_pkg::CNT_W-1:0] cnt_reg;
    logic [sjb_pkg::CNT_W-1:0] cnt_next;

    // Writes are always taken when idle; a tick needs room in the read stage.
    assign in_ready = (state_reg == ST_IDLE)
                      && ((command == sjb_pkg::CMD_WRITE) || status.rd_free);

    // Next-state and command decode.
    always_comb
    begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        cmd.write_en       = 1'b0;
        cmd.start_hit      = 1'b0;
        cmd.start_miss     = 1'b0;
        cmd.read_en        = 1'b0;
        cmd.read_idx       = '0;
        cmd.read_last      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (command == sjb_pkg::CMD_WRITE)
                    begin
                        cmd.write_en = 1'b1;
                    end
                    else if (status.slot_hit)
                    begin
                        cmd.start_hit = 1'b1;
                        cmd.read_en   = 1'b1;
                        cmd.read_last = (sjb_pkg::FRAME_WORDS == 1);
                        if (sjb_pkg::FRAME_WORDS > 1)
                        begin
                            state_next = ST_PLAY;
                            cnt_next   = sjb_pkg::CNT_W'(1);
                        end
                    end
                    else
                    begin
                        cmd.start_miss = 1'b1;
                    end
                end
            end
            ST_PLAY:
            begin
                if (status.rd_free)
                begin
                    cmd.read_en   = 1'b1;
                    cmd.read_idx  = cnt_reg;
                    cmd.read_last = (cnt_reg == sjb_pkg::CNT_W'(sjb_pkg::FRAME_WORDS - 1));
                    if (cmd.read_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + sjb_pkg::CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and word counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* rtl/sjb_datapath.sv */
// Datapath of the jitter buffer: slot ready bits, frame payload memory,
// playout counter, read stage and output register. Depends on sjb_pkg.
module sjb_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  sjb_pkg::ctrl_cmd_t  cmd,
    output sjb_pkg::dp_status_t status,
    input  logic [31:0]         packet_seq,
    input  logic                is_redundant,
    input  logic [4:0]          word_index,
    input  logic [63:0]         word_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         out_seq,
    output logic [4:0]          out_index,
    output logic [63:0]         out_value,
    output logic                missed,
    output logic                last_of_run
);

    localparam int SW = sjb_pkg::SLOT_W;
    localparam int CW = sjb_pkg::CNT_W;
    localparam int AW = sjb_pkg::ADDR_W;

    // Frame payload memory, one row of FRAME_WORDS words per slot.
    logic [63:0] mem [sjb_pkg::MEM_DEPTH];

    logic [sjb_pkg::SLOTS-1:0] slot_ready_reg;
    logic [sjb_pkg::SLOTS-1:0] slot_ready_next;
    logic [31:0]               play_counter_reg;
    logic [31:0]               play_seq_reg;
    logic [SW-1:0]             play_slot_reg;
    logic                      frame_accept_reg;
    logic                      frame_accept_next;
    logic [SW-1:0]             target_slot_reg;
    logic [SW-1:0]             target_slot_next;

    // Read stage: memory data plus the result's metadata.
    logic                      rd_valid_reg;
    logic [63:0]               rd_data_reg;
    logic [31:0]               rd_seq_reg;
    logic [4:0]                rd_idx_reg;
    logic                      rd_miss_reg;
    logic                      rd_last_reg;

    // Output register.
    logic                      out_valid_reg;
    logic [31:0]               out_seq_reg;
    logic [4:0]                out_index_reg;
    logic [63:0]               out_value_reg;
    logic                      missed_reg;
    logic                      last_reg;

    logic [SW-1:0]             cur_slot;
    logic [CW-1:0]             widx;
    logic                      in_range;
    logic                      is_first;
    logic                      is_last;
    logic                      drop_copy;
    logic [SW-1:0]             new_slot;
    logic [SW-1:0]             wr_slot;
    logic                      accept_now;
    logic                      store;
    logic [AW-1:0]             waddr;
    logic [SW-1:0]             rd_slot;
    logic [AW-1:0]             raddr;
    logic                      rd_load;
    logic                      rd_move;

    // Slot played by the next tick.
    assign cur_slot = play_counter_reg[SW-1:0];

    // Write path: slot choice on word zero, acceptance and last-word marking.
    assign widx       = CW'(word_index);
    assign in_range   = widx < CW'(sjb_pkg::FRAME_WORDS);
    assign is_first   = (word_index == 5'd0);
    assign is_last    = (widx == CW'(sjb_pkg::FRAME_WORDS - 1));
    assign drop_copy  = is_redundant && (packet_seq == 32'd0);
    assign new_slot   = packet_seq[SW-1:0] - SW'(is_redundant);
    assign wr_slot    = is_first ? new_slot : target_slot_reg;
    assign accept_now = is_first ? !slot_ready_reg[new_slot] : frame_accept_reg;
    assign store      = cmd.write_en && in_range && !(is_first && drop_copy) && accept_now;
    assign waddr      = AW'(wr_slot) * AW'(sjb_pkg::FRAME_WORDS) + AW'(widx);

    always_comb
    begin
        frame_accept_next = frame_accept_reg;
        target_slot_next  = target_slot_reg;
        slot_ready_next   = slot_ready_reg;
        if (cmd.write_en && in_range && is_first)
        begin
            if (drop_copy)
            begin
                frame_accept_next = 1'b0;
            end
            else
            begin
                target_slot_next  = new_slot;
                frame_accept_next = accept_now;
            end
        end
        if (store && is_last)
        begin
            slot_ready_next[wr_slot] = 1'b1;
            frame_accept_next        = 1'b0;
        end
        if (cmd.start_hit)
        begin
            slot_ready_next[cur_slot] = 1'b0;
        end
    end

    // Read address: word zero uses the current slot, later words the held one.
    assign rd_slot = cmd.start_hit ? cur_slot : play_slot_reg;
    assign raddr   = AW'(rd_slot) * AW'(sjb_pkg::FRAME_WORDS) + AW'(cmd.read_idx);

    // Read stage advances into the output register when that has room.
    assign rd_load = cmd.read_en || cmd.start_miss;
    assign rd_move = rd_valid_reg && (!out_valid_reg || out_ready);

    assign status.slot_hit = slot_ready_reg[cur_slot];
    assign status.rd_free  = !rd_valid_reg || rd_move;

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            mem[waddr] <= word_value;
        end
        if (cmd.read_en)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    // Control state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_ready_reg   <= '0;
            play_counter_reg <= '0;
            frame_accept_reg <= 1'b0;
            target_slot_reg  <= '0;
            rd_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            slot_ready_reg   <= slot_ready_next;
            frame_accept_reg <= frame_accept_next;
            target_slot_reg  <= target_slot_next;
            if (cmd.start_hit || cmd.start_miss)
            begin
                play_counter_reg <= play_counter_reg + 32'd1;
            end
            if (rd_load)
            begin
                rd_valid_reg <= 1'b1;
            end
            else if (rd_move)
            begin
                rd_valid_reg <= 1'b0;
            end
            if (rd_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the playout, read stage and output.
    always_ff @(posedge clk)
    begin
        if (cmd.start_hit)
        begin
            play_seq_reg  <= play_counter_reg;
            play_slot_reg <= cur_slot;
        end
        if (rd_load)
        begin
            rd_seq_reg  <= (cmd.start_hit || cmd.start_miss) ? play_counter_reg : play_seq_reg;
            rd_idx_reg  <= cmd.read_idx[4:0];
            rd_miss_reg <= cmd.start_miss;
            rd_last_reg <= cmd.start_miss || cmd.read_last;
        end
        if (rd_move)
        begin
            out_seq_reg   <= rd_seq_reg;
            out_index_reg <= rd_miss_reg ? 5'd0 : rd_idx_reg;
            out_value_reg <= rd_miss_reg ? 64'd0 : rd_data_reg;
            missed_reg    <= rd_miss_reg;
            last_reg      <= rd_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_seq     = out_seq_reg;
    assign out_index   = out_index_reg;
    assign out_value   = out_value_reg;
    assign missed      = missed_reg;
    assign last_of_run = last_reg;

endmodule

/* test/tb_top.sv */
// Self-checking testbench for seq_slot_jitter_buffer_core: a directed table
// and a random stream of frame words and playout ticks, checked against a
// slot-buffer predictor. Depends on sjb_pkg and the RTL of the block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sjb_pkg::*;

    localparam int RANDOM_ITEMS = 125;
    localparam int STALL_LIMIT  = 1000;
    localparam int IDLE_PCT     = 29;

    // One played word as it should leave the block.
    typedef struct packed {
        logic [31:0] seq;
        logic [4:0]  idx;
        logic [63:0] value;
        logic        miss;
        logic        last;
    } playout_t;

    // One row of the directed table; typed rows carry their own expectation.
    typedef struct {
        logic        cmd;
        logic [31:0] seq;
        logic        red;
        logic [4:0]  widx;
        logic [63:0] val;
        bit          typed;
        playout_t    want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic [31:0] packet_seq;
    logic        is_redundant;
    logic [4:0]  word_index;
    logic [63:0] word_value;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] out_seq;
    logic [4:0]  out_index;
    logic [63:0] out_value;
    logic        missed;
    logic        last_of_run;

    // Predictor state: ready bits, payload store and the frame being received.
    bit              slot_full [SLOTS];
    logic [63:0]     frame_mem [MEM_DEPTH];
    bit              mem_written [MEM_DEPTH];
    logic [31:0]     play_seq;
    bit              storing;
    logic [SLOT_W-1:0] cur_slot;

    playout_t pending_words[$];
    row_t     directed_rows[$];

    int  fail_count;
    int  item_count;
    int  results_checked;
    int  ticks_played;
    int  ticks_missed;
    bit  steady;

    seq_slot_jitter_buffer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .packet_seq   (packet_seq),
        .is_redundant (is_redundant),
        .word_index   (word_index),
        .word_value   (word_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_seq      (out_seq),
        .out_index    (out_index),
        .out_value    (out_value),
        .missed       (missed),
        .last_of_run  (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advance the slot buffer by one accepted word and queue what it plays.
    function automatic void slot_buffer_step(logic cmd, logic [31:0] seq, logic red,
                                             logic [4:0] widx, logic [63:0] val,
                                             bit push_expect);
        logic [31:0]       fnum;
        logic [SLOT_W-1:0] ps;
        int                base;
        playout_t          word;
        if (cmd == CMD_WRITE)
        begin
            if (widx >= FRAME_WORDS)
                return;
            if (widx == 0)
            begin
                // The redundant copy of frame zero has no frame to belong to.
                if (red && seq == 0)
                begin
                    storing = 1'b0;
                    return;
                end
                fnum = seq - {31'd0, red};
                cur_slot = SLOT_W'(fnum % SLOTS);
                storing = !slot_full[cur_slot];
            end
            if (!storing)
                return;
            base = int'(cur_slot) * FRAME_WORDS;
            frame_mem[base + widx] = val;
            mem_written[base + widx] = 1'b1;
            if (widx == FRAME_WORDS - 1)
            begin
                slot_full[cur_slot] = 1'b1;
                storing = 1'b0;
            end
            return;
        end
        // Playout tick: the whole frame on a ready slot, else one miss word.
        ps = SLOT_W'(play_seq % SLOTS);
        if (slot_full[ps])
        begin
            base = int'(ps) * FRAME_WORDS;
            for (int w = 0; w < FRAME_WORDS; w++)
            begin
                word.seq = play_seq;
                word.idx = w[4:0];
                word.value = frame_mem[base + w];
                word.miss = 1'b0;
                word.last = (w == FRAME_WORDS - 1);
                if (push_expect)
                    pending_words.push_back(word);
            end
            slot_full[ps] = 1'b0;
            ticks_played++;
        end
        else
        begin
            word.seq = play_seq;
            word.idx = '0;
            word.value = '0;
            word.miss = 1'b1;
            word.last = 1'b1;
            if (push_expect)
                pending_words.push_back(word);
            ticks_missed++;
        end
        play_seq = play_seq + 32'd1;
    endfunction

    // True when this write would mark a slot ready that still holds words
    // never written since reset; such a frame must never be played.
    function automatic bit completes_with_holes(logic [31:0] seq, logic red,
                                                logic [4:0] widx);
        bit                accept;
        logic [SLOT_W-1:0] s;
        logic [31:0]       fnum;
        if (widx != FRAME_WORDS - 1)
            return 1'b0;
        accept = storing;
        s = cur_slot;
        if (widx == 0)
        begin
            if (red && seq == 0)
                return 1'b0;
            fnum = seq - {31'd0, red};
            s = SLOT_W'(fnum % SLOTS);
            accept = !slot_full[s];
        end
        if (!accept)
            return 1'b0;
        for (int w = 0; w < FRAME_WORDS; w++)
            if (w != widx && !mem_written[int'(s) * FRAME_WORDS + w])
                return 1'b1;
        return 1'b0;
    endfunction

    // Present one word, hold it until taken, then update the predictor.
    task automatic send_word(logic cmd, logic [31:0] seq, logic red, logic [4:0] widx,
                             logic [63:0] val, bit push_expect);
        logic [4:0] idx_eff;
        idx_eff = widx;
        if (cmd == CMD_WRITE && completes_with_holes(seq, red, widx))
            idx_eff = 5'($urandom_range(31, FRAME_WORDS));
        if (!steady)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        packet_seq   <= seq;
        is_redundant <= red;
        word_index   <= idx_eff;
        word_value   <= val;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        if (cmd == CMD_TICK || idx_eff < FRAME_WORDS)
            item_count++;
        slot_buffer_step(cmd, seq, red, idx_eff, val, push_expect);
    endtask

    // Stream one frame; a broken frame keeps word 0 and drops others at random.
    task automatic send_frame(logic [31:0] fnum, logic red, bit broken);
        for (int w = 0; w < FRAME_WORDS; w++)
            if (!broken || w == 0 || $urandom_range(3) != 0)
                send_word(CMD_WRITE, red ? fnum + 32'd1 : fnum, red, w[4:0],
                          {$urandom, $urandom}, 1'b1);
    endtask

    task automatic add_row(logic cmd, logic [31:0] seq, logic red, logic [4:0] widx,
                           logic [63:0] val, bit typed, playout_t want);
        row_t r;
        r.cmd = cmd;
        r.seq = seq;
        r.red = red;
        r.widx = widx;
        r.val = val;
        r.typed = typed;
        r.want = want;
        directed_rows.push_back(r);
    endtask

    // Result checker: every taken word against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        playout_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            results_checked++;
            if (pending_words.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected word: seq %0d idx %0d value %h missed %b last %b",
                             out_seq, out_index, out_value, missed, last_of_run);
            end
            else
            begin
                want = pending_words.pop_front();
                if (out_seq !== want.seq || out_index !== want.idx ||
                    out_value !== want.value || missed !== want.miss ||
                    last_of_run !== want.last)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("mismatch: expected seq %0d idx %0d value %h missed %b last %b",
                                 want.seq, want.idx, want.value, want.miss, want.last);
                        $display("          got      seq %0d idx %0d value %h missed %b last %b",
                                 out_seq, out_index, out_value, missed, last_of_run);
                    end
                end
            end
        end
    end

    // Receiver stalls at random, except in the steady stretch.
    always @(posedge clk)
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

    // Watchdog: ends the run after too many cycles with no word taken.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_ready === 1'b1) ||
                (out_valid === 1'b1 && out_ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // Main stimulus: reset, directed table, random stream, drain.
    initial
    begin : stimulus
        playout_t no_word;
        playout_t miss_zero;
        int       random_start;
        int       choice;
        bit       paused;
        no_word = '0;
        miss_zero = '{seq: 32'd0, idx: 5'd0, value: 64'd0, miss: 1'b1, last: 1'b1};
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        command      <= CMD_WRITE;
        packet_seq   <= '0;
        is_redundant <= 1'b0;
        word_index   <= '0;
        word_value   <= '0;
        play_seq = '0;
        storing = 1'b0;
        cur_slot = '0;
        steady = 1'b0;
        paused = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: miss right after reset, dropped copy of frame zero,
        // an ignored index, then a redundant copy of frame 1 whose later
        // words carry junk sequence numbers, played by the next tick.
        add_row(CMD_TICK, 32'd0, 1'b0, 5'd0, 64'd0, 1'b1, miss_zero);
        add_row(CMD_WRITE, 32'd0, 1'b1, 5'd0, '1, 1'b0, no_word);
        add_row(CMD_WRITE, 32'd0, 1'b1, 5'(FRAME_WORDS - 1), '1, 1'b0, no_word);
        add_row(CMD_WRITE, '1, 1'b1, 5'd31, '1, 1'b0, no_word);
        for (int w = 0; w < FRAME_WORDS; w++)
            add_row(CMD_WRITE, (w == 0) ? 32'd2 : $urandom, 1'b1, w[4:0],
                    (w == 0) ? 64'd0 : (w == 1) ? '1 : {$urandom, $urandom},
                    1'b0, no_word);
        add_row(CMD_TICK, '1, 1'b1, 5'd31, '1, 1'b0, no_word);
        foreach (directed_rows[i])
        begin
            send_word(directed_rows[i].cmd, directed_rows[i].seq, directed_rows[i].red,
                      directed_rows[i].widx, directed_rows[i].val,
                      !directed_rows[i].typed);
            if (directed_rows[i].typed)
                pending_words.push_back(directed_rows[i].want);
        end

        // Random stream: mostly whole frames near the playout point, with
        // ticks, broken frames and stray words mixed in.
        random_start = item_count;
        while (item_count - random_start < RANDOM_ITEMS)
        begin
            if (!paused && item_count - random_start >= 60)
            begin
                // Hold the sender until every queued word has been played.
                in_valid <= 1'b0;
                while (pending_words.size() != 0)
                    @(posedge clk);
                paused = 1'b1;
            end
            steady = (item_count - random_start >= 90) &&
                     (item_count - random_start < 120);
            choice = $urandom_range(99);
            if (choice < 50)
                send_frame(play_seq + $urandom_range(3), 1'($urandom_range(1)), 1'b0);
            else if (choice < 75)
                send_word(CMD_TICK, $urandom, 1'($urandom_range(1)),
                          5'($urandom_range(31)), {$urandom, $urandom}, 1'b1);
            else if (choice < 85)
                send_frame(play_seq + $urandom_range(3), 1'($urandom_range(1)), 1'b1);
            else
                send_word(CMD_WRITE, $urandom, 1'($urandom_range(1)),
                          5'($urandom_range(31)), {$urandom, $urandom}, 1'b1);
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        // Drain, then give a late extra word time to show up.
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (FRAME_WORDS + 10) @(posedge clk);

        $display("summary: %0d words and ticks taken, %0d frames played, %0d ticks missed",
                 item_count, ticks_played, ticks_missed);
        $display("summary: %0d result words checked, %0d errors", results_checked, fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
